[rtl/address_blocklist_table_assert.svh]
// Assertion macros for the address blocklist table.
`ifndef ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH
`define ADDRESS_BLOCKLIST_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

`define ABT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ABT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ABT_ASSERT(lbl, clk, rst, prop, msg)

`define ABT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/abt_pkg.sv]
package abt_pkg;

   localparam int TABLE_DEPTH   = 64;
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int PFX_LVLS      = $clog2(TABLE_DEPTH);
   localparam int ADDR_W        = 32;
   localparam int MODE_W        = 2;
   localparam int ENTRY_COUNT_W = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   typedef struct packed {
      logic valid;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

[rtl/abt_cell.sv]
module abt_cell (
   input  logic                       clock,
   input  abt_pkg::cell_ctl_type      ctl,
   input  logic [abt_pkg::ADDR_W-1:0] addr,
   input  logic [abt_pkg::ADDR_W-1:0] next_entry,
   output logic [abt_pkg::ADDR_W-1:0] entry,
   output logic                       match
);

   logic [abt_pkg::ADDR_W-1:0] entry_ff;
   logic [abt_pkg::ADDR_W-1:0] entry_in;
   logic                       match_ff;
   logic                       match_in;

   always_comb begin
      priority if (ctl.load) begin
         entry_in = addr;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
      match_in = ctl.valid && (entry_ff == addr);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

[rtl/address_blocklist_table.sv]
// Blocklist of up to TABLE_DEPTH IPv4 addresses held in a row of cells, one entry per cell,
// packed from cell 0. Each word passes through a compare state, where every cell compares its
// entry with the address, then an update state, where the first match is found by a prefix OR
// across the row and the table is updated (add writes the cell at the fill count, remove
// makes each valid cell from the first match on, but the last, take its upper neighbor's entry).
// A back-to-back word is taken in the update state, once the previous result has room in the
// output register, so words never overlap. Adds to a full table report status 1.
`include "address_blocklist_table_assert.svh"

module address_blocklist_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [abt_pkg::MODE_W-1:0]        req_mode,
   input  logic [abt_pkg::ADDR_W-1:0]        req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_blocked,
   output logic                              rsp_status,
   output logic [abt_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);

   localparam int D = abt_pkg::TABLE_DEPTH;

   abt_pkg::state_type                 state_ff, state_in;
   abt_pkg::mode_type                  mode_ff, mode_in;
   logic [abt_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [abt_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_blocked_ff, rsp_blocked_in;
   logic                               rsp_status_ff, rsp_status_in;
   logic [abt_pkg::ENTRY_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                               out_free;
   logic                               fire;
   logic                               accept;
   logic                               full;
   logic                               any_match;
   logic                               do_add;
   logic                               do_remove;
   logic [D-1:0]                       match_vec;
   logic [D-1:0]                       load_vec;
   logic [D-1:0]                       shift_vec;
   logic [D-1:0]                       pfx [0:abt_pkg::PFX_LVLS];
   logic [abt_pkg::ADDR_W-1:0]         entry_vec [0:D];
   abt_pkg::cell_ctl_type              ctl_vec [0:D-1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = (state_ff == abt_pkg::ST_UPD) && out_free;
   assign req_ready = (state_ff == abt_pkg::ST_IDLE) || fire;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == abt_pkg::CNT_W'(D));
   assign any_match = pfx[abt_pkg::PFX_LVLS][D-1];
   assign do_add    = fire && (mode_ff == abt_pkg::MODE_ADD) && !full;
   assign do_remove = fire && (mode_ff == abt_pkg::MODE_REMOVE) && any_match;

   // first-match prefix OR, log-depth
   assign pfx[0] = match_vec;
   for (genvar l = 0; l < abt_pkg::PFX_LVLS; l++) begin : g_pfx
      for (genvar b = 0; b < D; b++) begin : g_bit
         if (b >= (1 << l)) begin : g_or
            assign pfx[l+1][b] = pfx[l][b] | pfx[l][b - (1 << l)];
         end else begin : g_pass
            assign pfx[l+1][b] = pfx[l][b];
         end
      end
   end

   assign entry_vec[D] = '0;

   for (genvar k = 0; k < D; k++) begin : g_cell
      assign load_vec[k]  = do_add && (count_ff == abt_pkg::CNT_W'(k));
      assign shift_vec[k] = do_remove && pfx[abt_pkg::PFX_LVLS][k]
                            && (abt_pkg::CNT_W'(k + 1) < count_ff);
      assign ctl_vec[k].valid = (abt_pkg::CNT_W'(k) < count_ff);
      assign ctl_vec[k].load  = load_vec[k];
      assign ctl_vec[k].shift = shift_vec[k];

      abt_cell u_cell (
         .clock      (clock),
         .ctl        (ctl_vec[k]),
         .addr       (addr_ff),
         .next_entry (entry_vec[k+1]),
         .entry      (entry_vec[k]),
         .match      (match_vec[k])
      );
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;

      if (accept) begin
         mode_in = abt_pkg::mode_type'(req_mode);
         addr_in = req_address;
      end

      if (do_add) begin
         count_in = count_ff + abt_pkg::CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - abt_pkg::CNT_W'(1);
      end

      if (fire) begin
         rsp_valid_in   = 1'b1;
         rsp_blocked_in = (mode_ff == abt_pkg::MODE_LOOKUP) && (|match_vec);
         rsp_status_in  = (mode_ff == abt_pkg::MODE_ADD) && full;
         rsp_count_in   = abt_pkg::ENTRY_COUNT_W'(count_in);
      end

      unique case (state_ff)
         abt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = abt_pkg::ST_CMP;
            end
         end
         abt_pkg::ST_CMP: begin
            state_in = abt_pkg::ST_UPD;
         end
         abt_pkg::ST_UPD: begin
            if (fire) begin
               state_in = accept ? abt_pkg::ST_CMP : abt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      addr_ff        <= addr_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_blocked     = rsp_blocked_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   `ABT_ASSERT(a_count_max, clock, reset, count_ff <= abt_pkg::CNT_W'(D), "count over depth")
   `ABT_ASSERT(a_one_load, clock, reset, $onehot0(load_vec), "more than one cell loaded")
   `ABT_ASSERT(a_upd_after_cmp, clock, reset, state_ff == abt_pkg::ST_UPD |-> $past(state_ff) == abt_pkg::ST_CMP || $past(state_ff) == abt_pkg::ST_UPD, "update without compare")
   `ABT_ASSERT(a_remove_dec, clock, reset, do_remove |=> count_ff == $past(count_ff) - abt_pkg::CNT_W'(1), "remove did not shrink count")
   `ABT_ASSERT(a_no_write_idle, clock, reset, !fire |-> (load_vec == '0) && (shift_vec == '0), "table written outside update")

endmodule

[tb/tb_address_blocklist_table.sv]
`timescale 1ns / 1ps

module tb_address_blocklist_table;

   localparam logic [abt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int N_DIRECTED = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_WORD = 150;
   localparam int POOL_MAX = 80;

   typedef struct packed {
      logic                              blocked;
      logic                              status;
      logic [abt_pkg::ENTRY_COUNT_W-1:0] entry_count;
   } verdict_type;

   typedef struct packed {
      logic [abt_pkg::MODE_W-1:0] mode;
      logic [abt_pkg::ADDR_W-1:0] address;
      logic                       pinned;
      verdict_type                v;
   } dir_row_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [abt_pkg::MODE_W-1:0]        req_mode = abt_pkg::MODE_LOOKUP;
   logic [abt_pkg::ADDR_W-1:0]        req_address = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_blocked;
   logic                              rsp_status;
   logic [abt_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count;

   // typed expectation travels with the word it belongs to
   logic        row_pinned = 1'b0;
   verdict_type row_verdict = '0;

   logic [abt_pkg::ADDR_W-1:0] blk_entries [abt_pkg::TABLE_DEPTH];
   int                         blk_count = 0;
   verdict_type                verdict_q [$];
   logic [abt_pkg::ADDR_W-1:0] addr_pool [$];
   int                         words_taken = 0;
   int                         errors = 0;
   int                         burst_left = 0;

   // lookup, add, remove weights per random phase: fill, mixed, drain, mixed
   int seg_len [4] = '{100, 130, 110, 90};
   int seg_lkp [4] = '{12, 35, 25, 30};
   int seg_add [4] = '{85, 30, 10, 35};
   int seg_rem [4] = '{2, 30, 63, 33};

   dir_row_type dir_rows [N_DIRECTED] = '{
      '{abt_pkg::MODE_LOOKUP, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{abt_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}},
      '{abt_pkg::MODE_ADD,    32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{abt_pkg::MODE_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{abt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{abt_pkg::MODE_LOOKUP, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{abt_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{abt_pkg::MODE_LOOKUP, 32'h0000_0001, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{MODE_UNUSED,          32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{abt_pkg::MODE_ADD,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{abt_pkg::MODE_ADD,    32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd4}},
      '{abt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{abt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 7'd3}},
      '{abt_pkg::MODE_REMOVE, 32'h1234_5678, 1'b1, '{1'b0, 1'b0, 7'd3}},
      '{abt_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd2}},
      '{abt_pkg::MODE_LOOKUP, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 7'd2}},
      '{abt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{abt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{MODE_UNUSED,          32'h0000_0000, 1'b1, '{1'b0, 1'b0, 7'd1}},
      '{abt_pkg::MODE_REMOVE, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 7'd0}}
   };

   address_blocklist_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_address     (req_address),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_blocked     (rsp_blocked),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_address_blocklist_table: done, errors");
      $finish;
   end

   function automatic verdict_type apply_word(input logic [abt_pkg::MODE_W-1:0] m,
                                              input logic [abt_pkg::ADDR_W-1:0] a);
      verdict_type v;
      int          hit;
      v = '0;
      hit = -1;
      for (int k = 0; k < blk_count; k++)
         if (hit < 0 && blk_entries[k] == a) hit = k;
      case (m)
         abt_pkg::MODE_LOOKUP: v.blocked = (hit >= 0);
         abt_pkg::MODE_ADD: begin
            if (blk_count >= abt_pkg::TABLE_DEPTH) begin
               v.status = 1'b1;
            end else begin
               blk_entries[blk_count] = a;
               blk_count++;
            end
         end
         abt_pkg::MODE_REMOVE: begin
            if (hit >= 0) begin
               for (int k = hit; k < blk_count - 1; k++) blk_entries[k] = blk_entries[k + 1];
               blk_count--;
            end
         end
         default: ;
      endcase
      v.entry_count = abt_pkg::ENTRY_COUNT_W'(blk_count);
      return v;
   endfunction

   function automatic logic [abt_pkg::ADDR_W-1:0] pick_addr();
      int r;
      int sel;
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 3);
      if (r < 45 && addr_pool.size() > 0)
         return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (r < 60 && addr_pool.size() > 0)
         return addr_pool[$urandom_range(0, addr_pool.size() - 1)]
                ^ (32'h1 << $urandom_range(0, 31));
      if (r < 75) begin
         case (sel)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return ~(32'h1 << $urandom_range(0, 31));
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_word(input logic [abt_pkg::MODE_W-1:0] m,
                            input logic [abt_pkg::ADDR_W-1:0] a,
                            input logic pinned, input verdict_type v);
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_address <= a;
      row_pinned  <= pinned;
      row_verdict <= v;
      do @(posedge clock); while (!req_ready);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 15);
      end else begin
         burst_left--;
      end
   endtask

   // prediction at input acceptance, comparison at result acceptance
   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = apply_word(req_mode, req_address);
            if (row_pinned) want = row_verdict;
            verdict_q.push_back(want);
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_blocked, rsp_status, rsp_entry_count};
            if (verdict_q.size() == 0) begin
               $display("%0t: result with nothing expected: blocked %0d status %0d count %0d",
                        $time, got.blocked, got.status, got.entry_count);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (got.blocked !== want.blocked) begin
                  $display("%0t: blocked expected %0d, got %0d",
                           $time, want.blocked, got.blocked);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count expected %0d, got %0d",
                           $time, want.entry_count, got.entry_count);
                  errors++;
               end
            end
         end
      end
   end

   // receiver: changing stall styles plus one long hold-off
   initial begin
      int  style;
      int  style_left;
      bit  held;
      style = 0;
      style_left = 0;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && words_taken >= HOLD_AT_WORD) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (style_left == 0) begin
               style = $urandom_range(0, 2);
               style_left = $urandom_range(10, 60);
            end
            style_left--;
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int                         r;
      logic [abt_pkg::MODE_W-1:0] m;
      logic [abt_pkg::ADDR_W-1:0] a;
      burst_left = $urandom_range(1, 15);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++)
         send_word(dir_rows[i].mode, dir_rows[i].address, dir_rows[i].pinned, dir_rows[i].v);

      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < seg_len[s]; i++) begin
            r = $urandom_range(0, 99);
            if (r < seg_lkp[s]) m = abt_pkg::MODE_LOOKUP;
            else if (r < seg_lkp[s] + seg_add[s]) m = abt_pkg::MODE_ADD;
            else if (r < seg_lkp[s] + seg_add[s] + seg_rem[s]) m = abt_pkg::MODE_REMOVE;
            else m = MODE_UNUSED;
            a = pick_addr();
            if (m == abt_pkg::MODE_ADD) begin
               addr_pool.push_back(a);
               if (addr_pool.size() > POOL_MAX) void'(addr_pool.pop_front());
            end
            send_word(m, a, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_address_blocklist_table: done, clean");
      end else begin
         $display("tb_address_blocklist_table: done, errors");
      end
      $finish;
   end

endmodule
